@@ design/bgd_pkg.sv @@
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types, codes and constants of the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

   localparam int TIME_WIDTH  = 32;
   localparam int COUNT_WIDTH = 8;
   localparam int CFG_WIDTH   = 16;
   localparam int PROD_WIDTH  = 2 * CFG_WIDTH;
   localparam int STEP_WIDTH  = $clog2(PROD_WIDTH);
   localparam int ADDR_WIDTH  = 3;
   localparam int CODE_WIDTH  = 3;
   localparam int REQ_DATA_WIDTH = ((1 + TIME_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((CODE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

   typedef logic [TIME_WIDTH-1:0]  time_type;
   typedef logic [CFG_WIDTH-1:0]   cfg_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam cfg_type DEBOUNCE_RST     = 16'd20;
   localparam cfg_type LONG_PRESS_RST   = 16'd800;
   localparam cfg_type CLICK_WINDOW_RST = 16'd300;

   typedef enum logic [1:0] {
      REQ_SAMPLE  = 2'd0,
      REQ_REPRESS = 2'd1,
      REQ_CLEAR   = 2'd2
   } req_kind_type;

   typedef enum logic [ADDR_WIDTH-1:0] {
      CSR_DEBOUNCE      = 3'd0,
      CSR_LONG_PRESS    = 3'd1,
      CSR_CLICK_WINDOW  = 3'd2,
      CSR_REPEAT_FIRST  = 3'd3,
      CSR_REPEAT_LAST   = 3'd4,
      CSR_REPEAT_RAMP   = 3'd5
   } csr_index_type;

   typedef enum logic [CODE_WIDTH-1:0] {
      GEST_NONE     = 3'd0,
      GEST_SINGLE   = 3'd1,
      GEST_MULTI    = 3'd2,
      GEST_LONG     = 3'd3,
      GEST_REPEAT   = 3'd4,
      GEST_RELEASED = 3'd5
   } gesture_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic mul;
      logic div_step;
      logic commit;
   } bgd_cmd_type;

   typedef struct packed {
      logic is_sample;
      logic need_div;
      logic out_free;
   } bgd_sts_type;

endpackage

@@ design/bgd_datapath.sv @@
// ----------------------------------------------------------------------------
// bgd_datapath
// Debounce, long press timer, click window, serial repeat period divider,
// configuration registers and result register.
// ----------------------------------------------------------------------------
module bgd_datapath
   import bgd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [ADDR_WIDTH-1:0]     csr_addr,
   input  logic [CFG_WIDTH-1:0]      csr_data,
   input  logic [1:0]                req_tuser,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  bgd_cmd_type               cmd,
   output bgd_sts_type               sts,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output logic                      rsp_tuser,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam count_type CLICK_MAX = '1;

   cfg_type debounce_ff, long_press_ff, click_window_ff;
   cfg_type rep_first_ff, rep_last_ff, rep_ramp_ff;

   logic [1:0] kind_ff, kind_in;
   logic       raw_ff, raw_in;
   time_type   now_ff, now_in;

   logic       last_raw_ff, last_raw_in;
   time_type   raw_change_time_ff, raw_change_time_in;
   logic       stable_level_ff, stable_level_in;
   logic       hold_timer_prev_ff, hold_timer_prev_in;
   time_type   hold_start_time_ff, hold_start_time_in;
   logic       press_edge_prev_ff, press_edge_prev_in;
   logic       hold_fire_prev_ff, hold_fire_prev_in;
   count_type  clicks_ff, clicks_in;
   time_type   window_open_time_ff, window_open_time_in;
   logic       window_open_ff, window_open_in;
   logic       long_active_ff, long_active_in;
   time_type   last_repeat_time_ff, last_repeat_time_in;
   time_type   long_begin_time_ff, long_begin_time_in;
   logic       wait_release_ff, wait_release_in;

   logic       st_ff, st_in;
   logic       rise_ff, rise_in;
   logic       ledge_ff, ledge_in;
   logic       ramp_in_ff, ramp_in_in;
   cfg_type    elapsed_ff, elapsed_in;

   logic [PROD_WIDTH-1:0] quo_ff, quo_in;
   cfg_type               rem_ff, rem_in;

   logic        rsp_valid_ff, rsp_valid_in;
   gesture_type code_ff, code_in;
   logic        cv_ff, cv_in;
   count_type   total_ff, total_in;

   // sample evaluation terms
   time_type  rct_c, hst_c, elapsed_c;
   logic      stable_c, hold_done_c, ramp_range_c;

   // divider and commit terms
   cfg_type                diff_c, period_c;
   logic [PROD_WIDTH-1:0]  prod_c;
   logic [CFG_WIDTH:0]     trial_c, trial_sub_c;
   logic                   trial_ge_c, descend_c, repeat_hit_c, window_due_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= DEBOUNCE_RST;
         long_press_ff   <= LONG_PRESS_RST;
         click_window_ff <= CLICK_WINDOW_RST;
         rep_first_ff    <= '0;
         rep_last_ff     <= '0;
         rep_ramp_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_addr)
            CSR_DEBOUNCE:     debounce_ff     <= csr_data;
            CSR_LONG_PRESS:   long_press_ff   <= csr_data;
            CSR_CLICK_WINDOW: click_window_ff <= csr_data;
            CSR_REPEAT_FIRST: rep_first_ff    <= csr_data;
            CSR_REPEAT_LAST:  rep_last_ff     <= csr_data;
            CSR_REPEAT_RAMP:  rep_ramp_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // debounce and on-delay timer
   always_comb begin
      rct_c        = (raw_ff != last_raw_ff) ? now_ff : raw_change_time_ff;
      stable_c     = ((now_ff - rct_c) >= TIME_WIDTH'(debounce_ff)) ? raw_ff
                                                                    : stable_level_ff;
      hst_c        = hold_timer_prev_ff ? hold_start_time_ff : now_ff;
      hold_done_c  = stable_c && ((now_ff - hst_c) >= TIME_WIDTH'(long_press_ff));
      elapsed_c    = now_ff - long_begin_time_ff;
      ramp_range_c = (rep_ramp_ff != '0) && (elapsed_c < TIME_WIDTH'(rep_ramp_ff));
   end

   // repeat period ramp
   always_comb begin
      descend_c    = rep_first_ff >= rep_last_ff;
      diff_c       = descend_c ? (rep_first_ff - rep_last_ff) : (rep_last_ff - rep_first_ff);
      prod_c       = PROD_WIDTH'(diff_c) * PROD_WIDTH'(elapsed_ff);
      trial_c      = {rem_ff, quo_ff[PROD_WIDTH-1]};
      trial_sub_c  = trial_c - {1'b0, rep_ramp_ff};
      trial_ge_c   = trial_c >= {1'b0, rep_ramp_ff};
      if (!ramp_in_ff) begin
         period_c = rep_last_ff;
      end else if (descend_c) begin
         period_c = rep_first_ff - quo_ff[CFG_WIDTH-1:0];
      end else begin
         period_c = rep_first_ff + quo_ff[CFG_WIDTH-1:0];
      end
      repeat_hit_c = (now_ff - last_repeat_time_ff) >= TIME_WIDTH'(period_c);
      window_due_c = (now_ff - window_open_time_ff) >= TIME_WIDTH'(click_window_ff);
   end

   always_comb begin
      sts.is_sample = kind_ff == REQ_SAMPLE;
      sts.need_div  = ramp_range_c && stable_c && long_active_ff && (rep_first_ff != '0);
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      kind_in             = kind_ff;
      raw_in              = raw_ff;
      now_in              = now_ff;
      last_raw_in         = last_raw_ff;
      raw_change_time_in  = raw_change_time_ff;
      stable_level_in     = stable_level_ff;
      hold_timer_prev_in  = hold_timer_prev_ff;
      hold_start_time_in  = hold_start_time_ff;
      press_edge_prev_in  = press_edge_prev_ff;
      hold_fire_prev_in   = hold_fire_prev_ff;
      clicks_in           = clicks_ff;
      window_open_time_in = window_open_time_ff;
      window_open_in      = window_open_ff;
      long_active_in      = long_active_ff;
      last_repeat_time_in = last_repeat_time_ff;
      long_begin_time_in  = long_begin_time_ff;
      wait_release_in     = wait_release_ff;
      st_in               = st_ff;
      rise_in             = rise_ff;
      ledge_in            = ledge_ff;
      ramp_in_in          = ramp_in_ff;
      elapsed_in          = elapsed_ff;
      quo_in              = quo_ff;
      rem_in              = rem_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_tready;
      code_in             = code_ff;
      cv_in               = cv_ff;
      total_in            = total_ff;

      if (cmd.load) begin
         kind_in = req_tuser;
         raw_in  = req_tdata[0];
         now_in  = req_tdata[TIME_WIDTH:1];
      end

      if (cmd.eval) begin
         unique case (kind_ff)
            REQ_SAMPLE: begin
               last_raw_in        = raw_ff;
               raw_change_time_in = rct_c;
               hold_timer_prev_in = stable_c;
               if (stable_c) begin
                  hold_start_time_in = hst_c;
               end
               press_edge_prev_in = stable_c;
               hold_fire_prev_in  = hold_done_c;
               stable_level_in    = stable_c;
               st_in              = stable_c;
               rise_in            = stable_c && !press_edge_prev_ff;
               ledge_in           = hold_done_c && !hold_fire_prev_ff;
               ramp_in_in         = ramp_range_c;
               elapsed_in         = elapsed_c[CFG_WIDTH-1:0];
            end
            REQ_REPRESS: begin
               wait_release_in = 1'b1;
               window_open_in  = 1'b0;
               clicks_in       = '0;
               long_active_in  = 1'b0;
            end
            REQ_CLEAR: begin
               last_raw_in         = 1'b0;
               raw_change_time_in  = '0;
               stable_level_in     = 1'b0;
               hold_timer_prev_in  = 1'b0;
               hold_start_time_in  = '0;
               press_edge_prev_in  = 1'b0;
               hold_fire_prev_in   = 1'b0;
               clicks_in           = '0;
               window_open_time_in = '0;
               window_open_in      = 1'b0;
               long_active_in      = 1'b0;
               last_repeat_time_in = '0;
               long_begin_time_in  = '0;
               wait_release_in     = 1'b0;
            end
            default: ;
         endcase
      end

      if (cmd.mul) begin
         quo_in = prod_c;
         rem_in = '0;
      end

      if (cmd.div_step) begin
         rem_in = trial_ge_c ? trial_sub_c[CFG_WIDTH-1:0] : trial_c[CFG_WIDTH-1:0];
         quo_in = {quo_ff[PROD_WIDTH-2:0], trial_ge_c};
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         code_in      = GEST_NONE;
         cv_in        = 1'b0;
         total_in     = '0;
         if (!(wait_release_ff && st_ff)) begin
            wait_release_in = 1'b0;
            if (rise_ff) begin
               if (!window_open_ff) begin
                  window_open_in      = 1'b1;
                  clicks_in           = count_type'(1);
                  window_open_time_in = now_ff;
                  long_active_in      = 1'b0;
               end else if (clicks_ff != CLICK_MAX) begin
                  clicks_in = clicks_ff + count_type'(1);
               end
            end
            priority if (ledge_ff) begin
               long_active_in      = 1'b1;
               clicks_in           = '0;
               window_open_in      = 1'b0;
               last_repeat_time_in = now_ff;
               long_begin_time_in  = now_ff;
               code_in             = GEST_LONG;
               cv_in               = 1'b1;
            end else if (long_active_in && st_ff && (rep_first_ff != '0) && repeat_hit_c) begin
               last_repeat_time_in = now_ff;
               code_in             = GEST_REPEAT;
            end else if (long_active_in && !st_ff) begin
               long_active_in = 1'b0;
               code_in        = GEST_RELEASED;
            end else if (window_open_in && window_due_c && !st_ff) begin
               if (!long_active_in && (clicks_in == count_type'(1))) begin
                  code_in = GEST_SINGLE;
               end else if (!long_active_in && (clicks_in != '0)) begin
                  code_in = GEST_MULTI;
               end
               cv_in          = 1'b1;
               total_in       = clicks_in;
               window_open_in = 1'b0;
               clicks_in      = '0;
               long_active_in = 1'b0;
            end else begin
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff         <= 1'b0;
         raw_change_time_ff  <= '0;
         stable_level_ff     <= 1'b0;
         hold_timer_prev_ff  <= 1'b0;
         hold_start_time_ff  <= '0;
         press_edge_prev_ff  <= 1'b0;
         hold_fire_prev_ff   <= 1'b0;
         clicks_ff           <= '0;
         window_open_time_ff <= '0;
         window_open_ff      <= 1'b0;
         long_active_ff      <= 1'b0;
         last_repeat_time_ff <= '0;
         long_begin_time_ff  <= '0;
         wait_release_ff     <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         last_raw_ff         <= last_raw_in;
         raw_change_time_ff  <= raw_change_time_in;
         stable_level_ff     <= stable_level_in;
         hold_timer_prev_ff  <= hold_timer_prev_in;
         hold_start_time_ff  <= hold_start_time_in;
         press_edge_prev_ff  <= press_edge_prev_in;
         hold_fire_prev_ff   <= hold_fire_prev_in;
         clicks_ff           <= clicks_in;
         window_open_time_ff <= window_open_time_in;
         window_open_ff      <= window_open_in;
         long_active_ff      <= long_active_in;
         last_repeat_time_ff <= last_repeat_time_in;
         long_begin_time_ff  <= long_begin_time_in;
         wait_release_ff     <= wait_release_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      raw_ff     <= raw_in;
      now_ff     <= now_in;
      st_ff      <= st_in;
      rise_ff    <= rise_in;
      ledge_ff   <= ledge_in;
      ramp_in_ff <= ramp_in_in;
      elapsed_ff <= elapsed_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      code_ff    <= code_in;
      cv_ff      <= cv_in;
      total_ff   <= total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = cv_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({total_ff, code_ff});

   a_clicks_track_window: assert property (@(posedge clock) disable iff (reset)
      (clicks_ff != '0) == window_open_ff)
      else $error("click count and window flag disagree");

   a_repress_quiet: assert property (@(posedge clock) disable iff (reset)
      wait_release_ff |-> (!long_active_ff && !window_open_ff))
      else $error("gesture state active while waiting for release");

   a_total_only_when_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !cv_ff) |-> (total_ff == '0))
      else $error("click total set without count valid");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rep_ramp_ff != '0))
      else $error("divider running with zero ramp time");

endmodule

@@ design/bgd_ctrl.sv @@
// ----------------------------------------------------------------------------
// bgd_ctrl
// Sequencer: accept, evaluate; a sample may multiply, serial divide, commit.
// ----------------------------------------------------------------------------
module bgd_ctrl
   import bgd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  bgd_sts_type sts,
   output bgd_cmd_type cmd
);

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(PROD_WIDTH - 1);

   ctrl_state_type state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            priority if (!sts.is_sample) begin
               state_in = ST_IDLE;
            end else if (sts.need_div) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      step_in      = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_EVAL:  cmd.eval = 1'b1;
         ST_MUL: begin
            cmd.mul = 1'b1;
            step_in = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_WIDTH'(1);
         end
         ST_COMMIT: cmd.commit = sts.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_mul_enters_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (state_ff == ST_DIV && step_ff == '0))
      else $error("divider not started from step zero");

   a_commit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && !sts.out_free) |=> (state_ff == ST_COMMIT))
      else $error("result dropped while output busy");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && $past(state_ff) == ST_DIV) |-> ($past(step_ff) == LAST_STEP))
      else $error("divider left early");

endmodule

@@ design/button_gesture_detector.sv @@
// ----------------------------------------------------------------------------
// button_gesture_detector
// Click, multi click and long press detector for one debounced push button.
// ----------------------------------------------------------------------------
// req channel: one transfer per timestamped item; tuser is the request kind
// (sample tick, require repress, clear), tdata carries raw level and time.
// rsp channel: one transfer per sample tick with the gesture code, and in
// tuser a flag marking a valid click total. Commands give no transfer.
// csr channel: register index and 16-bit value, always ready; write only
// while no item is in flight.
// A sample is accepted, evaluated and committed; while a long press is held
// inside the repeat ramp it also passes a 16x16 multiply and a 32-step
// serial divider for the repeat period. A command is only evaluated.
// A new item is taken once a command has been evaluated or a sample has
// reached the result register. If the receiver stalls, the result waits
// there and the next sample waits before commit, so nothing is lost.
// Reset restores the register defaults and clears all gesture state.
// ----------------------------------------------------------------------------
module button_gesture_detector
   import bgd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [1:0]                req_tuser,   // req_type
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // raw_level, time_ms, zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic                      rsp_tuser,   // count_valid
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // gesture_code, click_total, zero pad
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [ADDR_WIDTH-1:0]     csr_addr,
   input  logic [CFG_WIDTH-1:0]      csr_data
);

   bgd_cmd_type cmd;
   bgd_sts_type sts;

   assign csr_ready = 1'b1;

   bgd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bgd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
